>>> rtl/triac_phase_dimmer_core_defines.svh
// ----------------------------------------------------------------------------
// triac phase dimmer assertion macros
// check wrappers for the dimmer core, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef TRIAC_PHASE_DIMMER_CORE_DEFINES_SVH
`define TRIAC_PHASE_DIMMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TRPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("trpd check failed");

// next-cycle implication
`define TRPD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("trpd check failed");

`else

`define TRPD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TRPD_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/trpd_pkg.sv
// ----------------------------------------------------------------------------
// trpd_pkg
// shared types and constants of the triac phase dimmer
// ----------------------------------------------------------------------------
package trpd_pkg;

  // beat kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_ZC    = 2'd1;
  localparam logic [1:0] KIND_CMD   = 2'd2;
  localparam logic [1:0] KIND_MS    = 2'd3;

  // command modes
  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_ABS      = 3'd1;
  localparam logic [2:0] MODE_INC      = 3'd2;
  localparam logic [2:0] MODE_INC_DEF  = 3'd3;
  localparam logic [2:0] MODE_DEC      = 3'd4;
  localparam logic [2:0] MODE_DEC_DEF  = 3'd5;
  localparam logic [2:0] MODE_TOGGLE   = 3'd6;
  localparam logic [2:0] MODE_IGNORE   = 3'd7;

  // configuration register indexes
  localparam logic [2:0] CFG_TRIGGER_WIDTH = 3'd0;
  localparam logic [2:0] CFG_DELAY_MIN     = 3'd1;
  localparam logic [2:0] CFG_DELAY_MAX     = 3'd2;
  localparam logic [2:0] CFG_CLICK_WINDOW  = 3'd3;
  localparam logic [2:0] CFG_HOLD_TIME     = 3'd4;
  localparam logic [2:0] CFG_FADE_INTERVAL = 3'd5;
  localparam logic [2:0] CFG_DEFAULT_STEP  = 3'd6;

  // reset values
  localparam logic [15:0] TRIGGER_WIDTH_RST = 16'd2000;
  localparam logic [15:0] DELAY_MIN_RST     = 16'd720;
  localparam logic [15:0] DELAY_MAX_RST     = 16'd17920;
  localparam logic [15:0] CLICK_WINDOW_RST  = 16'd250;
  localparam logic [15:0] HOLD_TIME_RST     = 16'd500;
  localparam logic [15:0] FADE_INTERVAL_RST = 16'd10;
  localparam logic [7:0]  DEFAULT_STEP_RST  = 8'd10;
  localparam logic [15:0] COMPARE_RST       = 16'd20000;

  localparam int unsigned CLICK_DEADLINE_RST = 1000;
  localparam int unsigned LED_ON_MS          = 100;
  localparam int unsigned LED_GAP_MS         = 50;

  localparam logic [7:0] LEVEL_FULL = 8'hFF;
  localparam logic [7:0] LEVEL_OFF  = 8'h00;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         command_mode;
    logic signed [15:0] command_value;
    logic               key_pressed;
  } item_t;

  typedef struct packed {
    logic       gate;
    logic       led;
    logic [7:0] level;
    logic       report;
  } result_t;

  typedef struct packed {
    logic [15:0] trigger_width;
    logic [15:0] delay_min;
    logic [15:0] delay_max;
    logic [15:0] click_window_ms;
    logic [15:0] hold_time_ms;
    logic [15:0] fade_interval_ms;
    logic [7:0]  default_step;
  } cfg_t;

  typedef struct packed {
    logic       req;
    logic [7:0] val;
  } set_req_t;

endpackage

>>> rtl/trpd_in_if.sv
// ----------------------------------------------------------------------------
// trpd_in_if
// input channel: valid/ready with one dimmer event per beat
// ----------------------------------------------------------------------------
interface trpd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         command_mode;
  logic signed [15:0] command_value;
  logic               key_pressed;

  modport source (
    output valid, kind, command_mode, command_value, key_pressed,
    input  ready
  );

  modport sink (
    input  valid, kind, command_mode, command_value, key_pressed,
    output ready
  );
endinterface

>>> rtl/trpd_out_if.sv
// ----------------------------------------------------------------------------
// trpd_out_if
// result channel: valid/ready with gate, led and level per beat
// ----------------------------------------------------------------------------
interface trpd_out_if;
  logic       valid;
  logic       ready;
  logic       gate;
  logic       led;
  logic [7:0] level;
  logic       report;

  modport source (
    output valid, gate, led, level, report,
    input  ready
  );

  modport sink (
    input  valid, gate, led, level, report,
    output ready
  );
endinterface

>>> rtl/triac_phase_dimmer_core.sv
// ----------------------------------------------------------------------------
// triac_phase_dimmer_core
// phase-angle triac dimmer with command, key and led handling
// ----------------------------------------------------------------------------
// The core takes one event per beat on in_ch (timer tick, zero crossing,
// brightness command, or millisecond tick with the key level) and returns
// exactly one result beat on out_ch carrying the gate level, the led level,
// the brightness and a flag that the brightness was set. An event sits in
// an input register, is worked in one pass against the dimmer state and
// lands in the output register; a new beat is taken every cycle unless the
// result channel stalls or a crossing waits. The phase delay for a new
// brightness comes out of a three-stage multiply and divide-by-255
// pipeline; a zero-crossing beat that reaches the core while a setting is
// still in that pipeline waits in the input register until the pipeline
// has written the new delay. Configuration registers are written through
// cfg_we / cfg_index / cfg_data; the user must write them only while the core
// is idle, and the core itself does not enforce this.
// ----------------------------------------------------------------------------
`include "triac_phase_dimmer_core_defines.svh"

module triac_phase_dimmer_core #(
  parameter int TIME_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  trpd_in_if.sink       in_ch,
  trpd_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  // configuration registers
  trpd_pkg::cfg_t cfg_r;

  // input register
  logic            in_v_r;
  trpd_pkg::item_t in_item_r;

  // output register
  logic              out_v_r;
  trpd_pkg::result_t out_res_r;

  trpd_pkg::result_t  exec_res;
  trpd_pkg::set_req_t set_req;
  logic               pd_busy;
  logic [15:0]        phase_delay;
  logic               hazard;
  logic               fire;
  logic               in_take;

  // zero crossing must see the delay of the latest setting
  assign hazard  = (in_item_r.kind == trpd_pkg::KIND_ZC) & pd_busy;
  assign fire    = in_v_r & ~hazard & (~out_v_r | out_ch.ready);
  assign in_take = in_ch.valid & in_ch.ready;

  assign in_ch.ready = ~in_v_r | fire;

  // configuration write, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_width    <= trpd_pkg::TRIGGER_WIDTH_RST;
      cfg_r.delay_min        <= trpd_pkg::DELAY_MIN_RST;
      cfg_r.delay_max        <= trpd_pkg::DELAY_MAX_RST;
      cfg_r.click_window_ms  <= trpd_pkg::CLICK_WINDOW_RST;
      cfg_r.hold_time_ms     <= trpd_pkg::HOLD_TIME_RST;
      cfg_r.fade_interval_ms <= trpd_pkg::FADE_INTERVAL_RST;
      cfg_r.default_step     <= trpd_pkg::DEFAULT_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trpd_pkg::CFG_TRIGGER_WIDTH: cfg_r.trigger_width    <= cfg_data;
        trpd_pkg::CFG_DELAY_MIN:     cfg_r.delay_min        <= cfg_data;
        trpd_pkg::CFG_DELAY_MAX:     cfg_r.delay_max        <= cfg_data;
        trpd_pkg::CFG_CLICK_WINDOW:  cfg_r.click_window_ms  <= cfg_data;
        trpd_pkg::CFG_HOLD_TIME:     cfg_r.hold_time_ms     <= cfg_data;
        trpd_pkg::CFG_FADE_INTERVAL: cfg_r.fade_interval_ms <= cfg_data;
        trpd_pkg::CFG_DEFAULT_STEP:  cfg_r.default_step     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input beat register, refilled in the cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.kind          <= in_ch.kind;
      in_item_r.command_mode  <= in_ch.command_mode;
      in_item_r.command_value <= in_ch.command_value;
      in_item_r.key_pressed   <= in_ch.key_pressed;
    end
  end

  // single-pass state update
  trpd_exec #(
    .TIME_BITS (TIME_BITS)
  ) u_exec (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (in_item_r),
    .cfg         (cfg_r),
    .phase_delay (phase_delay),
    .result      (exec_res),
    .set_out     (set_req)
  );

  // brightness to phase delay
  trpd_delay_pipe u_delay (
    .clk         (clk),
    .rst_n       (rst_n),
    .set_in      (set_req),
    .delay_min   (cfg_r.delay_min),
    .delay_max   (cfg_r.delay_max),
    .busy        (pd_busy),
    .phase_delay (phase_delay)
  );

  // result register: holds until the sink takes the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= exec_res;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.gate   = out_res_r.gate;
  assign out_ch.led    = out_res_r.led;
  assign out_ch.level  = out_res_r.level;
  assign out_ch.report = out_res_r.report;

  // checks

  // a zero crossing never runs on a stale phase delay
  `TRPD_ASSERT_IMP(a_zc_no_stale_delay, clk, rst_n,
    fire && (in_item_r.kind == trpd_pkg::KIND_ZC), !pd_busy)

  // every brightness setting starts the delay pipeline
  `TRPD_ASSERT_NXT(a_set_starts_pipe, clk, rst_n, set_req.req, pd_busy)

  // the gate can only rise on a timer tick beat
  `TRPD_ASSERT_IMP(a_gate_rise_on_tick, clk, rst_n,
    $rose(out_res_r.gate),
    $past(fire) && ($past(in_item_r.kind) == trpd_pkg::KIND_TICK))

endmodule

>>> rtl/trpd_delay_pipe.sv
// ----------------------------------------------------------------------------
// trpd_delay_pipe
// brightness to phase delay: multiply, divide by 255, offset; three stages
// ----------------------------------------------------------------------------
module trpd_delay_pipe (
  input  logic                    clk,
  input  logic                    rst_n,
  input  trpd_pkg::set_req_t      set_in,
  input  logic [15:0]             delay_min,
  input  logic [15:0]             delay_max,
  output logic                    busy,
  output logic [15:0]             phase_delay
);

  logic              v1_r, v2_r, v3_r;
  logic [7:0]        val_r;
  logic [15:0]       dmin_r, dmax_r;
  logic [15:0]       dmax2_r, dmax3_r;
  logic              neg2_r, neg3_r;
  logic [23:0]       mag2_r, mag3_r;
  logic [16:0]       q0_r;
  logic [15:0]       phase_delay_r;

  logic signed [16:0] span;
  logic signed [25:0] prod;
  logic [25:0]        prod_abs;
  logic [24:0]        est_sum;
  logic [24:0]        q0_x255;
  logic [24:0]        rem;
  logic [15:0]        q_fix;
  logic [15:0]        pd_nxt;

  // stage 1: signed product val * (delay_min - delay_max)
  always_comb begin
    span     = $signed({1'b0, dmin_r}) - $signed({1'b0, dmax_r});
    prod     = $signed({1'b0, val_r}) * span;
    prod_abs = prod[25] ? 26'(-prod) : 26'(prod);
  end

  // stage 2: quotient estimate, low by at most one
  always_comb begin
    est_sum = 25'(mag2_r) + 25'(mag2_r >> 8) + 25'(mag2_r >> 16);
  end

  // stage 3: one correction step and offset from delay_max
  always_comb begin
    q0_x255 = {q0_r, 8'd0} - 25'(q0_r);
    rem     = 25'(mag3_r) - q0_x255;
    q_fix   = (rem >= 25'd255) ? 16'(q0_r + 17'd1) : q0_r[15:0];
    pd_nxt  = neg3_r ? (dmax3_r - q_fix) : (dmax3_r + q_fix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      phase_delay_r <= trpd_pkg::DELAY_MAX_RST;
    end else begin
      v1_r <= set_in.req;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v3_r) begin
        phase_delay_r <= pd_nxt;
      end
    end
  end

  // delay range taken together with the level and carried down the stages
  always_ff @(posedge clk) begin
    if (set_in.req) begin
      val_r  <= set_in.val;
      dmin_r <= delay_min;
      dmax_r <= delay_max;
    end
    neg2_r  <= prod[25];
    mag2_r  <= prod_abs[23:0];
    dmax2_r <= dmax_r;
    neg3_r  <= neg2_r;
    mag3_r  <= mag2_r;
    dmax3_r <= dmax2_r;
    q0_r    <= est_sum[24:8];
  end

  assign busy        = v1_r | v2_r | v3_r;
  assign phase_delay = phase_delay_r;

endmodule

>>> rtl/trpd_exec.sv
// ----------------------------------------------------------------------------
// trpd_exec
// dimmer state and the single-pass update for one event
// ----------------------------------------------------------------------------
module trpd_exec #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  trpd_pkg::item_t       item,
  input  trpd_pkg::cfg_t        cfg,
  input  logic [15:0]           phase_delay,
  output trpd_pkg::result_t     result,
  output trpd_pkg::set_req_t    set_out
);

  localparam int TW = TIME_BITS;

  logic [15:0]   tick_r, tick_nxt;
  logic [15:0]   cmp_r, cmp_nxt;
  logic          pend_r, pend_nxt;
  logic          gate_r, gate_nxt;
  logic          en_r, en_nxt;
  logic [7:0]    bright_r, bright_nxt;
  logic          fade_up_r, fade_up_nxt;
  logic [TW-1:0] now_r, now_nxt;
  logic          key_r, key_nxt;
  logic [TW-1:0] chg_r, chg_nxt;
  logic [TW-1:0] dl_r, dl_nxt;
  logic [TW-1:0] nf_r, nf_nxt;
  logic          led_r, led_nxt;
  logic [TW-1:0] loff_r, loff_nxt;
  logic [TW-1:0] lnext_r, lnext_nxt;

  logic [15:0]   tick_inc;
  logic [TW-1:0] now_inc;
  logic [7:0]    cval8;
  logic          set_req;
  logic [7:0]    set_val;

  always_comb begin
    tick_nxt    = tick_r;
    cmp_nxt     = cmp_r;
    pend_nxt    = pend_r;
    gate_nxt    = gate_r;
    en_nxt      = en_r;
    bright_nxt  = bright_r;
    fade_up_nxt = fade_up_r;
    now_nxt     = now_r;
    key_nxt     = key_r;
    chg_nxt     = chg_r;
    dl_nxt      = dl_r;
    nf_nxt      = nf_r;
    led_nxt     = led_r;
    loff_nxt    = loff_r;
    lnext_nxt   = lnext_r;
    set_req     = 1'b0;
    set_val     = trpd_pkg::LEVEL_OFF;
    tick_inc    = tick_r + 16'd1;
    now_inc     = now_r + TW'(1);
    cval8       = item.command_value[7:0];

    unique case (item.kind)
      trpd_pkg::KIND_TICK: begin
        tick_nxt = tick_inc;
        if (tick_inc == cmp_r) begin
          if (pend_r) begin
            cmp_nxt  = cmp_r + cfg.trigger_width;
            gate_nxt = 1'b1;
            pend_nxt = 1'b0;
          end else begin
            gate_nxt = 1'b0;
          end
        end
      end
      trpd_pkg::KIND_ZC: begin
        if (en_r) begin
          cmp_nxt  = tick_r + phase_delay;
          pend_nxt = 1'b1;
          gate_nxt = 1'b0;
        end
      end
      trpd_pkg::KIND_CMD: begin
        set_req = 1'b1;
        unique case (item.command_mode)
          trpd_pkg::MODE_OFF:     set_val = trpd_pkg::LEVEL_OFF;
          trpd_pkg::MODE_ABS:     set_val = cval8;
          trpd_pkg::MODE_INC:     set_val = bright_r + cval8;
          trpd_pkg::MODE_INC_DEF: set_val = bright_r + cfg.default_step;
          trpd_pkg::MODE_DEC:     set_val = bright_r - cval8;
          trpd_pkg::MODE_DEC_DEF: set_val = bright_r - cfg.default_step;
          trpd_pkg::MODE_TOGGLE: begin
            set_val = (bright_r != trpd_pkg::LEVEL_FULL) ? trpd_pkg::LEVEL_FULL
                                                         : trpd_pkg::LEVEL_OFF;
          end
          default: set_req = 1'b0;
        endcase
      end
      default: begin
        now_nxt = now_inc;
        if (now_inc > loff_r) begin
          led_nxt = 1'b0;
        end
        priority if (item.key_pressed && !key_r) begin
          key_nxt = 1'b1;
          chg_nxt = now_inc;
          dl_nxt  = now_inc + TW'(cfg.click_window_ms);
        end else if (!item.key_pressed && key_r) begin
          key_nxt = 1'b0;
          chg_nxt = now_inc;
          if (now_inc < dl_r) begin
            set_req = 1'b1;
            set_val = fade_up_r ? trpd_pkg::LEVEL_FULL : trpd_pkg::LEVEL_OFF;
          end
        end else if (item.key_pressed &&
                     ((now_inc - chg_r) > TW'(cfg.hold_time_ms))) begin
          if (now_inc > nf_r) begin
            set_req = 1'b1;
            set_val = fade_up_r ? (bright_r + 8'd1) : (bright_r - 8'd1);
            nf_nxt  = now_inc + TW'(cfg.fade_interval_ms);
          end
        end else begin
          key_nxt = key_r;
        end
      end
    endcase

    // brightness setting: led blink, enable and fade direction
    if (set_req) begin
      if (now_nxt > lnext_r) begin
        led_nxt   = 1'b1;
        loff_nxt  = now_nxt + TW'(trpd_pkg::LED_ON_MS);
        lnext_nxt = now_nxt + TW'(trpd_pkg::LED_ON_MS + trpd_pkg::LED_GAP_MS);
      end
      bright_nxt = set_val;
      en_nxt     = (set_val != trpd_pkg::LEVEL_OFF);
      if (set_val == trpd_pkg::LEVEL_FULL) begin
        fade_up_nxt = 1'b0;
      end else if (set_val == trpd_pkg::LEVEL_OFF) begin
        fade_up_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= 16'd0;
      cmp_r     <= trpd_pkg::COMPARE_RST;
      pend_r    <= 1'b0;
      gate_r    <= 1'b0;
      en_r      <= 1'b0;
      bright_r  <= trpd_pkg::LEVEL_OFF;
      fade_up_r <= 1'b0;
      now_r     <= '0;
      key_r     <= 1'b0;
      chg_r     <= '0;
      dl_r      <= TW'(trpd_pkg::CLICK_DEADLINE_RST);
      nf_r      <= '0;
      led_r     <= 1'b0;
      loff_r    <= '0;
      lnext_r   <= '0;
    end else if (fire) begin
      tick_r    <= tick_nxt;
      cmp_r     <= cmp_nxt;
      pend_r    <= pend_nxt;
      gate_r    <= gate_nxt;
      en_r      <= en_nxt;
      bright_r  <= bright_nxt;
      fade_up_r <= fade_up_nxt;
      now_r     <= now_nxt;
      key_r     <= key_nxt;
      chg_r     <= chg_nxt;
      dl_r      <= dl_nxt;
      nf_r      <= nf_nxt;
      led_r     <= led_nxt;
      loff_r    <= loff_nxt;
      lnext_r   <= lnext_nxt;
    end
  end

  assign result.gate   = gate_nxt;
  assign result.led    = led_nxt;
  assign result.level  = bright_nxt;
  assign result.report = set_req;

  assign set_out.req = fire & set_req;
  assign set_out.val = set_val;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the triac phase dimmer core: each accepted event
// runs through a behavioural copy of the dimmer and the one result beat it
// causes is checked field by field, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RUN_LIMIT = 400000;   // time units, far above the slowest run
  localparam int TAIL_CYCLES = 20;     // settle time after the last result

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  trpd_in_if  in_ch ();
  trpd_out_if out_ch ();

  triac_phase_dimmer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // shadow of the dimmer: registers and state
  // --------------------------------------------------------------------------
  logic [15:0] m_trigger_width, m_delay_min, m_delay_max;
  logic [15:0] m_click_window, m_hold_time, m_fade_interval;
  logic [7:0]  m_default_step;

  logic [15:0] tick_cnt, cmp_val, delay_now;
  bit          trig_armed, gate_q, xing_en, fading_up, key_q, led_q;
  logic [7:0]  bright;
  logic [31:0] ms_now, key_edge_at, click_until, fade_due, led_off, led_gap_end;

  trpd_pkg::result_t due_results[$];   // one expected result beat per accepted event
  int      mismatches = 0;
  int      items_sent = 0;   // events that the core does not simply ignore
  int      gap_pct = 0;      // chance of a sender gap before a beat
  int      stall_pct = 0;    // chance of a receiver stall burst

  function automatic void dimmer_reset();
    m_trigger_width = trpd_pkg::TRIGGER_WIDTH_RST;
    m_delay_min     = trpd_pkg::DELAY_MIN_RST;
    m_delay_max     = trpd_pkg::DELAY_MAX_RST;
    m_click_window  = trpd_pkg::CLICK_WINDOW_RST;
    m_hold_time     = trpd_pkg::HOLD_TIME_RST;
    m_fade_interval = trpd_pkg::FADE_INTERVAL_RST;
    m_default_step  = trpd_pkg::DEFAULT_STEP_RST;
    tick_cnt    = '0;
    cmp_val     = trpd_pkg::COMPARE_RST;
    delay_now   = trpd_pkg::DELAY_MAX_RST;
    trig_armed  = 1'b0;
    gate_q      = 1'b0;
    xing_en     = 1'b0;
    fading_up   = 1'b0;
    key_q       = 1'b0;
    led_q       = 1'b0;
    bright      = trpd_pkg::LEVEL_OFF;
    ms_now      = '0;
    key_edge_at = '0;
    click_until = trpd_pkg::CLICK_DEADLINE_RST;
    fade_due    = '0;
    led_off     = '0;
    led_gap_end = '0;
  endfunction

  // a brightness setting: led blink, delay mapping, fade direction
  function automatic void apply_brightness(logic [7:0] val);
    int dmin_i;
    int dmax_i;
    int val_i;
    int scaled;
    dmin_i = m_delay_min;
    dmax_i = m_delay_max;
    val_i  = val;
    if (ms_now > led_gap_end) begin
      led_off     = ms_now + trpd_pkg::LED_ON_MS;
      led_gap_end = led_off + trpd_pkg::LED_GAP_MS;
      led_q       = 1'b1;
    end
    if (val == trpd_pkg::LEVEL_OFF) begin
      delay_now = m_delay_max;
      xing_en   = 1'b0;
    end else begin
      // signed span, quotient truncated toward zero
      scaled    = (val_i * (dmin_i - dmax_i)) / 255;
      delay_now = 16'(dmax_i + scaled);
      xing_en   = 1'b1;
    end
    bright = val;
    if (val == trpd_pkg::LEVEL_FULL) begin
      fading_up = 1'b0;
    end else if (val == trpd_pkg::LEVEL_OFF) begin
      fading_up = 1'b1;
    end
  endfunction

  function automatic trpd_pkg::result_t dimmer_step(trpd_pkg::item_t ev);
    trpd_pkg::result_t r;
    bit         set_flag;
    logic [7:0] b;
    logic [7:0] cv8;
    set_flag = 1'b0;
    b        = bright;
    cv8      = ev.command_value[7:0];
    case (ev.kind)
      trpd_pkg::KIND_TICK: begin
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt == cmp_val) begin
          if (trig_armed) begin
            cmp_val    = cmp_val + m_trigger_width;
            gate_q     = 1'b1;
            trig_armed = 1'b0;
          end else begin
            gate_q = 1'b0;
          end
        end
      end
      trpd_pkg::KIND_ZC: begin
        if (xing_en) begin
          cmp_val    = tick_cnt + delay_now;
          trig_armed = 1'b1;
          gate_q     = 1'b0;
        end
      end
      trpd_pkg::KIND_CMD: begin
        set_flag = 1'b1;
        case (ev.command_mode)
          trpd_pkg::MODE_OFF:     apply_brightness(trpd_pkg::LEVEL_OFF);
          trpd_pkg::MODE_ABS:     apply_brightness(cv8);
          trpd_pkg::MODE_INC:     apply_brightness(b + cv8);
          trpd_pkg::MODE_INC_DEF: apply_brightness(b + m_default_step);
          trpd_pkg::MODE_DEC:     apply_brightness(b - cv8);
          trpd_pkg::MODE_DEC_DEF: apply_brightness(b - m_default_step);
          trpd_pkg::MODE_TOGGLE: begin
            apply_brightness(b != trpd_pkg::LEVEL_FULL ? trpd_pkg::LEVEL_FULL
                                                       : trpd_pkg::LEVEL_OFF);
          end
          default:      set_flag = 1'b0;
        endcase
      end
      trpd_pkg::KIND_MS: begin
        ms_now = ms_now + 32'd1;
        if (ms_now > led_off) led_q = 1'b0;
        if (ev.key_pressed && !key_q) begin
          key_q       = 1'b1;
          key_edge_at = ms_now;
          click_until = ms_now + m_click_window;
        end else if (!ev.key_pressed && key_q) begin
          key_q       = 1'b0;
          key_edge_at = ms_now;
          if (ms_now < click_until) begin
            apply_brightness(fading_up ? trpd_pkg::LEVEL_FULL : trpd_pkg::LEVEL_OFF);
            set_flag = 1'b1;
          end
        end else if (ev.key_pressed && (ms_now - key_edge_at) > m_hold_time) begin
          if (ms_now > fade_due) begin
            apply_brightness(fading_up ? b + 8'd1 : b - 8'd1);
            set_flag = 1'b1;
            fade_due = ms_now + m_fade_interval;
          end
        end
      end
    endcase
    r.gate   = gate_q;
    r.led    = led_q;
    r.level  = bright;
    r.report = set_flag;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_event(trpd_pkg::item_t ev);
    bit counts;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.kind          = ev.kind;
    in_ch.command_mode  = ev.command_mode;
    in_ch.command_value = ev.command_value;
    in_ch.key_pressed   = ev.key_pressed;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    counts = !((ev.kind == trpd_pkg::KIND_CMD &&
                ev.command_mode == trpd_pkg::MODE_IGNORE) ||
               (ev.kind == trpd_pkg::KIND_ZC && !xing_en));
    due_results.push_back(dimmer_step(ev));
    if (counts) items_sent++;
    @(negedge clk);
  endtask

  function automatic trpd_pkg::item_t mk_event(logic [1:0] k, logic [2:0] m,
                                               logic [15:0] v, logic key);
    trpd_pkg::item_t ev;
    ev.kind          = k;
    ev.command_mode  = m;
    ev.command_value = v;
    ev.key_pressed   = key;
    return ev;
  endfunction

  task automatic send_tick();
    send_event(mk_event(trpd_pkg::KIND_TICK, trpd_pkg::MODE_OFF, 16'h0000, 1'b0));
  endtask

  task automatic send_zc();
    send_event(mk_event(trpd_pkg::KIND_ZC, trpd_pkg::MODE_OFF, 16'h0000, 1'b0));
  endtask

  task automatic send_cmd(logic [2:0] m, logic [15:0] v);
    send_event(mk_event(trpd_pkg::KIND_CMD, m, v, 1'b0));
  endtask

  task automatic send_ms(logic key);
    send_event(mk_event(trpd_pkg::KIND_MS, trpd_pkg::MODE_OFF, 16'h0000, key));
  endtask

  // stop sending and wait until every outstanding result beat is back
  task automatic settle();
    in_ch.valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // register write, only ever issued while the core is idle
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      trpd_pkg::CFG_TRIGGER_WIDTH: m_trigger_width = val;
      trpd_pkg::CFG_DELAY_MIN:     m_delay_min     = val;
      trpd_pkg::CFG_DELAY_MAX:     m_delay_max     = val;
      trpd_pkg::CFG_CLICK_WINDOW:  m_click_window  = val;
      trpd_pkg::CFG_HOLD_TIME:     m_hold_time     = val;
      trpd_pkg::CFG_FADE_INTERVAL: m_fade_interval = val;
      trpd_pkg::CFG_DEFAULT_STEP:  m_default_step  = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [15:0] tw, logic [15:0] dmin, logic [15:0] dmax,
                              logic [15:0] click, logic [15:0] hold,
                              logic [15:0] fade, logic [7:0] step);
    write_reg(trpd_pkg::CFG_TRIGGER_WIDTH, tw);
    write_reg(trpd_pkg::CFG_DELAY_MIN, dmin);
    write_reg(trpd_pkg::CFG_DELAY_MAX, dmax);
    write_reg(trpd_pkg::CFG_CLICK_WINDOW, click);
    write_reg(trpd_pkg::CFG_HOLD_TIME, hold);
    write_reg(trpd_pkg::CFG_FADE_INTERVAL, fade);
    write_reg(trpd_pkg::CFG_DEFAULT_STEP, {8'h00, step});
  endtask

  // receiver side: random stall bursts on ready, changed at falling edges
  initial begin : result_backpressure
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    trpd_pkg::result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        flag_mismatch("result beat with nothing outstanding", 8'h00, out_ch.level);
      end else begin
        want = due_results.pop_front();
        if (out_ch.gate !== want.gate)     flag_mismatch("gate", want.gate, out_ch.gate);
        if (out_ch.led !== want.led)       flag_mismatch("led", want.led, out_ch.led);
        if (out_ch.level !== want.level)   flag_mismatch("level", want.level, out_ch.level);
        if (out_ch.report !== want.report) flag_mismatch("report", want.report, out_ch.report);
      end
    end
  end

  // --------------------------------------------------------------------------
  // directed tests
  // --------------------------------------------------------------------------

  // timer tick, ignored crossing while disabled, first millisecond
  task automatic test_idle_after_reset();
    send_tick();
    send_zc();
    send_ms(1'b0);
  endtask

  // every command mode, operand extremes and mod 256 wrap in both directions
  task automatic test_command_modes();
    send_cmd(trpd_pkg::MODE_OFF, 16'h0000);      // first setting also starts a blink
    send_cmd(trpd_pkg::MODE_ABS, 16'h7FFF);      // low byte full, fade turns down
    send_cmd(trpd_pkg::MODE_INC, 16'h0001);      // wraps to off
    send_cmd(trpd_pkg::MODE_INC_DEF, 16'h0000);
    send_cmd(trpd_pkg::MODE_DEC, 16'hFFFF);      // 10 - 255 wraps
    send_cmd(trpd_pkg::MODE_DEC_DEF, 16'h0000);
    send_cmd(trpd_pkg::MODE_DEC_DEF, 16'h0000);  // below zero
    send_cmd(trpd_pkg::MODE_TOGGLE, 16'h0000);
    send_cmd(trpd_pkg::MODE_TOGGLE, 16'h0000);
    send_cmd(trpd_pkg::MODE_IGNORE, 16'h1234);   // no change, no report
    send_cmd(trpd_pkg::MODE_ABS, 16'h8000);      // most negative operand, low byte zero
  endtask

  // gate rise and fall after a crossing, plus the zero phase delay case
  task automatic test_gate_timing();
    settle();
    write_reg(trpd_pkg::CFG_TRIGGER_WIDTH, 16'd2);
    write_reg(trpd_pkg::CFG_DELAY_MIN, 16'd0);
    write_reg(trpd_pkg::CFG_DELAY_MAX, 16'd4);
    // full brightness maps to no delay: compare lands on the current count,
    // so nothing fires until the timer has wrapped right round
    send_cmd(trpd_pkg::MODE_ABS, 16'h00FF);
    send_zc();
    send_tick();
    send_tick();
    // lowest brightness: four ticks to the gate, two more to drop it
    send_cmd(trpd_pkg::MODE_ABS, 16'h0001);
    send_zc();
    repeat (6) send_tick();
  endtask

  // press and release well inside the click window
  task automatic test_key_click();
    send_ms(1'b1);
    send_ms(1'b0);
  endtask

  // --------------------------------------------------------------------------
  // random traffic, mostly well-formed dimmer activity
  // --------------------------------------------------------------------------
  task automatic apply_setting(int which);
    case (which)
      0: load_setting(16'd3, 16'd1, 16'd20, 16'd6, 16'd4, 16'd1, 8'd7);
      1: load_setting(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
      2: load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      3: load_setting(16'd5, 16'd30, 16'd2, 16'd3, 16'd10, 16'd3, 8'd200);
      4: load_setting(16'd2, 16'd0, 16'hFFFF, 16'd12, 16'd2, 16'd5, 8'd128);
      5: load_setting(trpd_pkg::TRIGGER_WIDTH_RST, trpd_pkg::DELAY_MIN_RST,
                      trpd_pkg::DELAY_MAX_RST, trpd_pkg::CLICK_WINDOW_RST,
                      trpd_pkg::HOLD_TIME_RST, trpd_pkg::FADE_INTERVAL_RST,
                      trpd_pkg::DEFAULT_STEP_RST);
      default: load_setting(16'($urandom_range(1, 16)), 16'($urandom_range(0, 40)),
                            16'($urandom_range(0, 40)), 16'($urandom_range(0, 20)),
                            16'($urandom_range(0, 20)), 16'($urandom_range(0, 6)),
                            8'($urandom));
    endcase
  endtask

  // optional new level, a crossing and enough ticks to see the pulse when the delay is short
  task automatic burst_gate();
    int n;
    if ($urandom_range(0, 1)) send_cmd(trpd_pkg::MODE_ABS, 16'($urandom));
    send_zc();
    n = delay_now + m_trigger_width + $urandom_range(0, 4);
    if (n > 48) n = $urandom_range(8, 48);
    repeat (n) send_tick();
  endtask

  // key held, past the hold time when that is short, so the level fades
  task automatic burst_hold();
    int n;
    n = m_hold_time + $urandom_range(1, 20);
    if (n > 40) n = 40;
    send_ms(1'b1);
    repeat (n) send_ms(1'b1);
    send_ms(1'b0);
  endtask

  task automatic burst_click();
    send_ms(1'b1);
    repeat ($urandom_range(0, 6)) send_ms(1'b1);
    send_ms(1'b0);
  endtask

  task automatic test_mixed_traffic(int which, int n_items, bit calm);
    int start;
    int pick;
    settle();
    apply_setting(which);
    start = items_sent;
    while (items_sent - start < n_items) begin
      // idling switches on and off per stretch, never in the calm phase
      gap_pct   = (calm || $urandom_range(0, 3) == 0) ? 0 : 20;
      stall_pct = (calm || $urandom_range(0, 3) == 0) ? 0 : 20;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        burst_gate();
      end else if (pick < 50) begin
        burst_hold();
      end else if (pick < 65) begin
        burst_click();
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 3)) send_cmd(3'($urandom_range(0, 7)), 16'($urandom));
      end else begin
        // noise: any kind, any field contents
        repeat ($urandom_range(1, 4))
          send_event(mk_event(2'($urandom), 3'($urandom), 16'($urandom), 1'($urandom)));
      end
    end
    gap_pct   = 0;
    stall_pct = 0;
    settle();
  endtask

  // --------------------------------------------------------------------------
  // sequence of tests
  // --------------------------------------------------------------------------
  initial begin : run_tests
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = trpd_pkg::CFG_TRIGGER_WIDTH;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = trpd_pkg::KIND_TICK;
    in_ch.command_mode  = trpd_pkg::MODE_OFF;
    in_ch.command_value = '0;
    in_ch.key_pressed   = 1'b0;
    dimmer_reset();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_idle_after_reset();
    test_command_modes();
    test_gate_timing();
    test_key_click();

    test_mixed_traffic(0, 350, 1'b0);   // short delays, fast keys
    test_mixed_traffic(1, 250, 1'b0);   // every register at its floor but the trigger width at one
    test_mixed_traffic(2, 200, 1'b0);   // every register at its ceiling
    test_mixed_traffic(3, 300, 1'b0);   // delay rises with brightness
    test_mixed_traffic(4, 200, 1'b0);   // widest span
    test_mixed_traffic(5, 150, 1'b0);   // back to reset values
    test_mixed_traffic(6, 250, 1'b0);   // random small setting
    test_mixed_traffic(6, 300, 1'b1);   // no idling at all

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/trpd_pkg.sv
rtl/trpd_in_if.sv
rtl/trpd_out_if.sv
rtl/trpd_delay_pipe.sv
rtl/trpd_exec.sv
rtl/triac_phase_dimmer_core.sv
dv/tb_top.sv
